@@ hw/rtl/srtf_pkg.sv @@
`timescale 1ns / 1ps

package srtf_pkg;

    // default table size
    localparam int DEF_MAX_PROCS = 16;

    // fixed field widths
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 21;
    localparam int ID_W    = 5;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_CALC,
        ST_EMIT
    } t_state;

    // scan unit status toward the sequencer
    typedef struct packed {
        logic have_pick;
        logic have_next;
    } t_scan_flags;

endpackage

@@ hw/rtl/srtf_ram.sv @@
`timescale 1ns / 1ps

module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/srtf_scan.sv @@
`timescale 1ns / 1ps

module srtf_scan #(
    parameter int IDX_W  = 4,
    parameter int TICK_W = 21
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clr,
    input  logic                        i_vld,
    input  logic [IDX_W-1:0]            i_idx,
    input  logic                        i_done,
    input  logic [srtf_pkg::ARR_W-1:0]  i_arrival,
    input  logic [srtf_pkg::BURST_W-1:0] i_burst,
    input  logic [srtf_pkg::BURST_W-1:0] i_remain,
    input  logic [TICK_W-1:0]           i_start_tick,
    input  logic [TICK_W-1:0]           i_now,
    output srtf_pkg::t_scan_flags       o_flags,
    output logic [IDX_W-1:0]            o_pick_idx,
    output logic [srtf_pkg::ARR_W-1:0]  o_arrival,
    output logic [srtf_pkg::BURST_W-1:0] o_burst,
    output logic [srtf_pkg::BURST_W-1:0] o_remain,
    output logic [TICK_W-1:0]           o_start_tick,
    output logic [srtf_pkg::ARR_W-1:0]  o_next_arr
);

    import srtf_pkg::*;

    logic                r_have_pick;
    logic                r_have_next;
    logic [IDX_W-1:0]    r_pick_idx;
    logic [ARR_W-1:0]    r_arrival;
    logic [BURST_W-1:0]  r_burst;
    logic [BURST_W-1:0]  r_remain;
    logic [TICK_W-1:0]   r_start_tick;
    logic [ARR_W-1:0]    r_next_arr;

    logic ready;
    logic take_pick;
    logic take_next;

    // compare one entry against the running best
    always_comb begin
        ready     = !i_done && (TICK_W'(i_arrival) <= i_now);
        take_pick = i_vld && ready && (!r_have_pick || (i_remain < r_remain));
        take_next = i_vld && !i_done && (!r_have_next || (i_arrival < r_next_arr));
    end

    // running best control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_have_pick <= 1'b0;
            r_have_next <= 1'b0;
        end else begin
            if (take_pick) begin
                r_have_pick <= 1'b1;
            end
            if (take_next) begin
                r_have_next <= 1'b1;
            end
        end
    end

    // captured entry of the current pick and earliest pending arrival
    always_ff @(posedge i_clk) begin
        if (take_pick) begin
            r_pick_idx   <= i_idx;
            r_arrival    <= i_arrival;
            r_burst      <= i_burst;
            r_remain     <= i_remain;
            r_start_tick <= i_start_tick;
        end
        if (take_next) begin
            r_next_arr <= i_arrival;
        end
    end

    assign o_flags.have_pick = r_have_pick;
    assign o_flags.have_next = r_have_next;
    assign o_pick_idx        = r_pick_idx;
    assign o_arrival         = r_arrival;
    assign o_burst           = r_burst;
    assign o_remain          = r_remain;
    assign o_start_tick      = r_start_tick;
    assign o_next_arr        = r_next_arr;

endmodule

@@ hw/rtl/srtf_schedule_simulator_top.sv @@
`timescale 1ns / 1ps

// Shortest-remaining-time-first scheduler. Each process loads while i_start is high
// and o_busy is low; the item with i_final_item set also starts the run and o_busy
// stays high until the last completion record is emitted, falling as it appears. Every
// simulated tick costs one pass over the process table through its single read port
// plus the decide state, and a completing tick adds the calc and emit states for the
// record. A stretch with no ready process is skipped in one pass. Records appear
// for one cycle with o_valid and cannot be held off by the receiver.
module srtf_schedule_simulator_top #(
    parameter int MAX_PROCS = srtf_pkg::DEF_MAX_PROCS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [srtf_pkg::ARR_W-1:0]    i_arrival,
    input  logic [srtf_pkg::BURST_W-1:0]  i_burst,
    input  logic                          i_final_item,
    output logic                          o_valid,
    output logic [srtf_pkg::ID_W-1:0]     o_proc_id,
    output logic [srtf_pkg::TIME_W-1:0]   o_completion_time,
    output logic [srtf_pkg::TIME_W-1:0]   o_turnaround_time,
    output logic [srtf_pkg::TIME_W-1:0]   o_waiting_time,
    output logic [srtf_pkg::TIME_W-1:0]   o_response_time,
    output logic                          o_last_result
);

    import srtf_pkg::*;

    localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int TICK_W = ARR_W + $clog2(MAX_PROCS + 1);
    localparam int WORD_W = ARR_W + 2 * BURST_W + TICK_W;

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]     r_loaded;
    logic [CNT_W-1:0]     r_finished;
    logic [TICK_W-1:0]    r_now;
    logic [CNT_W-1:0]     r_scan_cnt;
    logic                 r_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [MAX_PROCS-1:0] r_started;
    logic [MAX_PROCS-1:0] r_done;

    logic [IDX_W-1:0]     r_cur_idx;
    logic [ARR_W-1:0]     r_cur_arr;
    logic [BURST_W-1:0]   r_cur_burst;
    logic [TICK_W-1:0]    r_cur_start;
    logic [TICK_W-1:0]    r_tat;
    logic [TICK_W-1:0]    r_resp;

    logic                 r_valid;
    logic [ID_W-1:0]      r_proc_id;
    logic [TIME_W-1:0]    r_completion;
    logic [TIME_W-1:0]    r_turnaround;
    logic [TIME_W-1:0]    r_waiting;
    logic [TIME_W-1:0]    r_response;
    logic                 r_last;

    logic                 load_xfer;
    logic                 load_store;
    logic                 issue;
    logic                 scan_clr;
    logic                 last_done;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WORD_W-1:0]    ram_rdata;

    t_scan_flags          scan_flags;
    logic [IDX_W-1:0]     pick_idx;
    logic [ARR_W-1:0]     pick_arr;
    logic [BURST_W-1:0]   pick_burst;
    logic [BURST_W-1:0]   pick_rem;
    logic [TICK_W-1:0]    pick_start;
    logic [ARR_W-1:0]     next_arr;

    logic [BURST_W-1:0]   upd_rem;
    logic [TICK_W-1:0]    upd_start;
    logic [TICK_W-1:0]    upd_now;
    logic                 upd_complete;
    logic [TICK_W-1:0]    idle_now;

    // handshake and scan control
    always_comb begin
        load_xfer  = i_start && (r_state == ST_IDLE);
        load_store = load_xfer && (r_loaded < CNT_W'(MAX_PROCS));
        issue      = (r_state == ST_SCAN) && (r_scan_cnt < r_loaded);
        scan_clr   = (r_state == ST_SCAN) && (r_scan_cnt == '0);
        last_done  = (r_finished == r_loaded);
    end

    // per-tick update of the picked process
    always_comb begin
        upd_start    = r_started[pick_idx] ? pick_start : r_now;
        upd_rem      = (pick_rem != '0) ? (pick_rem - 1'b1) : pick_rem;
        upd_now      = (pick_rem != '0) ? (r_now + 1'b1) : r_now;
        upd_complete = (upd_rem == '0);
        if (!scan_flags.have_next || (TICK_W'(next_arr) <= r_now)) begin
            idle_now = r_now + 1'b1;
        end else begin
            idle_now = TICK_W'(next_arr);
        end
    end

    // table write port: loads when idle, write-back after a pick
    always_comb begin
        if (r_state == ST_DECIDE) begin
            ram_we    = scan_flags.have_pick;
            ram_waddr = pick_idx;
            ram_wdata = {pick_arr, pick_burst, upd_rem, upd_start};
        end else begin
            ram_we    = load_store;
            ram_waddr = r_loaded[IDX_W-1:0];
            ram_wdata = {i_arrival, i_burst, i_burst, TICK_W'(0)};
        end
    end

    srtf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_PROCS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_scan_cnt[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    srtf_scan #(
        .IDX_W  (IDX_W),
        .TICK_W (TICK_W)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clr        (scan_clr),
        .i_vld        (r_rd_vld),
        .i_idx        (r_rd_idx),
        .i_done       (r_done[r_rd_idx]),
        .i_arrival    (ram_rdata[WORD_W-1 -: ARR_W]),
        .i_burst      (ram_rdata[WORD_W-ARR_W-1 -: BURST_W]),
        .i_remain     (ram_rdata[TICK_W+BURST_W-1 -: BURST_W]),
        .i_start_tick (ram_rdata[TICK_W-1:0]),
        .i_now        (r_now),
        .o_flags      (scan_flags),
        .o_pick_idx   (pick_idx),
        .o_arrival    (pick_arr),
        .o_burst      (pick_burst),
        .o_remain     (pick_rem),
        .o_start_tick (pick_start),
        .o_next_arr   (next_arr)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (load_xfer && i_final_item) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!issue) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (scan_flags.have_pick && upd_complete) begin
                    n_state = ST_CALC;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_CALC: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                n_state = last_done ? ST_IDLE : ST_SCAN;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // run control: counts, time, flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded   <= '0;
            r_finished <= '0;
            r_now      <= '0;
            r_scan_cnt <= '0;
            r_rd_vld   <= 1'b0;
            r_started  <= '0;
            r_done     <= '0;
        end else begin
            r_rd_vld <= issue;
            if (issue) begin
                r_scan_cnt <= r_scan_cnt + 1'b1;
            end else if (r_state != ST_SCAN) begin
                r_scan_cnt <= '0;
            end
            if (load_store) begin
                r_loaded                       <= r_loaded + 1'b1;
                r_started[r_loaded[IDX_W-1:0]] <= 1'b0;
                r_done[r_loaded[IDX_W-1:0]]    <= 1'b0;
            end
            if (r_state == ST_DECIDE) begin
                if (scan_flags.have_pick) begin
                    r_now               <= upd_now;
                    r_started[pick_idx] <= 1'b1;
                    if (upd_complete) begin
                        r_done[pick_idx] <= 1'b1;
                        r_finished       <= r_finished + 1'b1;
                    end
                end else begin
                    r_now <= idle_now;
                end
            end
            if ((r_state == ST_EMIT) && last_done) begin
                r_loaded   <= '0;
                r_finished <= '0;
                r_now      <= '0;
                r_started  <= '0;
                r_done     <= '0;
            end
        end
    end

    // read pipeline index and completion datapath
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_scan_cnt[IDX_W-1:0];
        if (r_state == ST_DECIDE) begin
            r_cur_idx   <= pick_idx;
            r_cur_arr   <= pick_arr;
            r_cur_burst <= pick_burst;
            r_cur_start <= upd_start;
        end
        if (r_state == ST_CALC) begin
            r_tat  <= r_now - TICK_W'(r_cur_arr);
            r_resp <= r_cur_start - TICK_W'(r_cur_arr);
        end
        if (r_state == ST_EMIT) begin
            r_proc_id    <= ID_W'({1'b0, r_cur_idx} + 1'b1);
            r_completion <= TIME_W'(r_now);
            r_turnaround <= TIME_W'(r_tat);
            r_waiting    <= TIME_W'(r_tat - TICK_W'(r_cur_burst));
            r_response   <= TIME_W'(r_resp);
            r_last       <= last_done;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == ST_EMIT);
        end
    end

    assign o_busy            = (r_state != ST_IDLE);
    assign o_valid           = r_valid;
    assign o_proc_id         = r_proc_id;
    assign o_completion_time = r_completion;
    assign o_turnaround_time = r_turnaround;
    assign o_waiting_time    = r_waiting;
    assign o_response_time   = r_response;
    assign o_last_result     = r_last;

endmodule
